FILE: hw/rtl/ray_sphere_closest_hit_assert.svh
// Assertion macros shared by the ray-sphere closest hit RTL
`ifndef RAY_SPHERE_CLOSEST_HIT_ASSERT_SVH
`define RAY_SPHERE_CLOSEST_HIT_ASSERT_SVH

// Checked on every clock edge outside reset
`define RSCH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every clock edge, reset included
`define RSCH_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: hw/rtl/rsch_pkg.sv
// Shared types and constants for the ray-sphere closest hit block
`timescale 1ns / 1ps

package rsch_pkg;

  localparam int FRAC_BITS = 16;   // Q16.16 coordinates
  localparam int MA_W      = 40;   // multiplier wide operand
  localparam int MB_W      = 20;   // multiplier chunk operand
  localparam int P_W       = MA_W + MB_W;
  localparam int ACC_W     = 80;   // accumulator, holds the discriminant
  localparam int X_W       = 74;   // discriminant bits fed to the root
  localparam int ROOT_W    = X_W / 2;
  localparam int REM_W     = ROOT_W + 5;
  localparam int SQ_STEPS  = ROOT_W;
  localparam int T_W       = 42;   // signed root distance
  localparam int STEP_W    = 6;

  // Control of the shared multiply-accumulate unit
  typedef struct packed {
    logic            en;    // add the term into the accumulator
    logic            clr;   // clear the accumulator
    logic [MA_W-1:0] a;
    logic [MB_W-1:0] b;
    logic            neg;   // subtract instead of add
    logic            sh;    // term weighted by 2^MB_W (upper chunk)
  } mac_ctl_t;

endpackage

FILE: hw/rtl/rsch_mac.sv
// Shared multiply-accumulate unit: one 40x20 product per cycle, signed accumulate
`timescale 1ns / 1ps

module rsch_mac
  import rsch_pkg::*;
(
  input  logic                    clk,
  input  mac_ctl_t                ctl,
  output logic signed [ACC_W-1:0] acc,
  output logic signed [ACC_W-1:0] term
);

  logic [P_W-1:0]   prod;
  logic [ACC_W-1:0] ext;
  logic [ACC_W-1:0] shd;

  // product, chunk weight and sign
  always_comb begin
    prod = ctl.a * ctl.b;
    ext  = ACC_W'(prod);
    shd  = ctl.sh ? (ext << MB_W) : ext;
    term = ctl.neg ? -$signed(shd) : $signed(shd);
  end

  // accumulator
  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      acc <= '0;
    end else if (ctl.en) begin
      acc <= acc + term;
    end
  end

endmodule

FILE: hw/rtl/ray_sphere_closest_hit.sv
// Ray-sphere closest hit: sphere table, sequencer and result register
//
// Input stream (s_*): tuser is the item kind, 0 loads a sphere into a table slot,
// 1 casts a ray. A load is written into its table slot as it is taken and gives no result. A cast gives one
// result on the output stream (m_*): tuser is the hit flag, tdata the slot, distance,
// inside flag and hit point. On a miss slot, distance and inside are zero and the
// point is the ray origin.
// For each tested sphere whose discriminant is not negative a cast runs 13 products on
// the shared multiply-accumulate unit and the 37-step bit-serial square root; a sphere
// missed by the discriminant test skips the square root. When some sphere was hit the
// hit point is then computed axis by axis, and last the output register is loaded.
// The spheres tested are sphere_count clamped to MAX_SPHERES. s_tready is low while a
// cast is in work, so one item is in the block at a time. The result sits in an output
// register: a stalled receiver holds it there while new items are accepted; a finished
// cast waits until that register is free. cfg_* writes sphere_count and is always ready;
// the user must write it only while idle, which the block itself does not enforce.
// Reset (rst, synchronous) clears sphere_count and the handshakes; the sphere
// table is not cleared and a slot must be loaded before a ray is cast against it.
`timescale 1ns / 1ps

`include "ray_sphere_closest_hit_assert.svh"

module ray_sphere_closest_hit
  import rsch_pkg::*;
#(
  parameter int MAX_SPHERES = 16
)(
  input  logic         clk,
  input  logic         rst,
  // config write
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [4:0]   cfg_data,     // sphere_count
  // request in
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [191:0] s_tdata,      // slot, pos_x, pos_y, pos_z, dir_x, dir_y, dir_z,
                                     // sphere_radius_in, zero fill
  input  logic         s_tuser,      // kind
  // result out
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [135:0] m_tdata,      // sphere_index, distance, inside_res, hit_x, hit_y,
                                     // hit_z, zero fill
  output logic         m_tuser       // hit
);

  localparam int IW = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
  localparam int KW = $clog2(MAX_SPHERES + 1);

  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic [30:0]        r;
  } sph_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD, ST_OMC, ST_DOT, ST_BC, ST_QUAD, ST_CHK, ST_SQRT, ST_ROOT,
    ST_HIT, ST_FIN
  } state_t;

  // input fields
  logic [3:0]         in_slot;
  logic signed [31:0] in_pos [3];
  logic signed [17:0] in_dir [3];
  logic [30:0]        in_rad;

  assign in_slot   = s_tdata[3:0];
  assign in_pos[0] = s_tdata[35:4];
  assign in_pos[1] = s_tdata[67:36];
  assign in_pos[2] = s_tdata[99:68];
  assign in_dir[0] = s_tdata[117:100];
  assign in_dir[1] = s_tdata[135:118];
  assign in_dir[2] = s_tdata[153:136];
  assign in_rad    = s_tdata[184:154];

  state_t              state;
  logic [STEP_W-1:0]   step;
  logic [KW-1:0]       k;
  logic [4:0]          count;
  logic signed [31:0]  org [3];
  logic [17:0]         dir_mag [3];
  logic [2:0]          dir_sgn;
  logic [MA_W-1:0]     omc_mag [3];
  logic [2:0]          omc_sgn;
  logic [MA_W-1:0]     rad;
  logic signed [MA_W-1:0] bq;
  logic [MA_W-1:0]     bmag;
  logic [X_W-1:0]      sq_x;
  logic [REM_W-1:0]    sq_rem;
  logic [ROOT_W-1:0]   sq_root;
  logic                found;
  logic [IW-1:0]       best_k;
  logic signed [T_W-1:0] best_t;
  logic                best_in;
  logic signed [31:0]  hp [3];
  sph_t                mem [MAX_SPHERES];
  sph_t                ent;

  // output register
  logic                o_hit;
  logic [3:0]          o_idx;
  logic [30:0]         o_dist;
  logic                o_ins;
  logic signed [31:0]  o_pt [3];

  mac_ctl_t            ctl;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] term;

  logic                load_acc;
  logic                cast_acc;
  logic [KW-1:0]       k_nx;
  logic                more;
  logic [STEP_W-1:0]   qi;
  logic [1:0]          qax;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign load_acc  = s_tvalid && s_tready && !s_tuser;
  assign cast_acc  = s_tvalid && s_tready && s_tuser;

  assign m_tuser = o_hit;
  assign m_tdata = {4'b0, o_pt[2], o_pt[1], o_pt[0], o_ins, o_dist, o_idx};

  // sphere table
  always_ff @(posedge clk) begin
    if (load_acc && (32'(in_slot) < 32'(MAX_SPHERES))) begin
      mem[IW'(in_slot)] <= '{cx: in_pos[0], cy: in_pos[1], cz: in_pos[2], r: in_rad};
    end
    if (state == ST_RD) begin
      ent <= mem[k[IW-1:0]];
    end
  end

  // multiply-accumulate control
  assign qi  = step - STEP_W'(4);
  assign qax = qi[2:1];

  always_comb begin
    ctl = '0;
    unique case (state)
      ST_OMC, ST_BC: begin
        ctl.clr = 1'b1;
      end
      ST_DOT: begin
        ctl.en  = 1'b1;
        ctl.a   = omc_mag[step[1:0]];
        ctl.b   = MB_W'(dir_mag[step[1:0]]);
        ctl.neg = omc_sgn[step[1:0]] ^ dir_sgn[step[1:0]];
      end
      ST_QUAD: begin
        ctl.en = 1'b1;
        case (step)
          STEP_W'(0): begin
            ctl.a = bmag;
            ctl.b = bmag[MB_W-1:0];
          end
          STEP_W'(1): begin
            ctl.a  = bmag;
            ctl.b  = bmag[MA_W-1:MB_W];
            ctl.sh = 1'b1;
          end
          STEP_W'(2): begin
            ctl.a = rad;
            ctl.b = rad[MB_W-1:0];
          end
          STEP_W'(3): begin
            ctl.a  = rad;
            ctl.b  = rad[MA_W-1:MB_W];
            ctl.sh = 1'b1;
          end
          default: begin
            // minus |origin - centre|^2, two chunks per axis
            ctl.a   = omc_mag[qax];
            ctl.b   = qi[0] ? omc_mag[qax][MA_W-1:MB_W] : omc_mag[qax][MB_W-1:0];
            ctl.sh  = qi[0];
            ctl.neg = 1'b1;
          end
        endcase
      end
      ST_HIT: begin
        ctl.a   = best_t[MA_W-1:0];
        ctl.b   = MB_W'(dir_mag[step[1:0]]);
        ctl.neg = dir_sgn[step[1:0]];
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

  rsch_mac u_mac (
    .clk  (clk),
    .ctl  (ctl),
    .acc  (acc),
    .term (term)
  );

  // next sphere
  assign k_nx = k + KW'(1);
  assign more = (32'(k_nx) < 32'(MAX_SPHERES)) && (32'(k_nx) < 32'(count));

  // root choice
  logic signed [T_W-1:0] negb, t_near, t_far, t_sel;
  logic                  t_ok, upd;
  always_comb begin
    negb   = -T_W'(bq);
    t_near = negb - $signed(T_W'(sq_root));
    t_far  = negb + $signed(T_W'(sq_root));
    t_ok   = !t_near[T_W-1] || !t_far[T_W-1];
    t_sel  = t_near[T_W-1] ? t_far : t_near;
    upd    = t_ok && (!found || (t_sel < best_t));
  end

  // square root step
  logic [REM_W-1:0] rem_sh, trial;
  assign rem_sh = {sq_rem[REM_W-3:0], sq_x[X_W-1:X_W-2]};
  assign trial  = REM_W'({sq_root, 2'b01});

  // hit point from the product term
  logic signed [63:0] pt_sum;
  logic signed [31:0] pt_sat;
  always_comb begin
    pt_sum = 64'(org[step[1:0]]) + term[ACC_W-1:FRAC_BITS];
    if (pt_sum > 64'sd2147483647) begin
      pt_sat = 32'sh7FFFFFFF;
    end else if (pt_sum < -64'sd2147483648) begin
      pt_sat = 32'sh80000000;
    end else begin
      pt_sat = pt_sum[31:0];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
      count    <= '0;
      step     <= '0;
      found    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        count <= cfg_data;
      end
      // a result taken while the next one is loaded is replaced, not cleared
      if (m_tvalid && m_tready && (state != ST_FIN)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (cast_acc) begin
            for (int i = 0; i < 3; i++) begin
              org[i]     <= in_pos[i];
              dir_sgn[i] <= in_dir[i][17];
              dir_mag[i] <= in_dir[i][17] ? 18'(-in_dir[i]) : 18'(in_dir[i]);
            end
            found <= 1'b0;
            k     <= '0;
            state <= (count != 5'd0) ? ST_RD : ST_FIN;
          end
        end
        ST_RD: begin
          state <= ST_OMC;
        end
        ST_OMC: begin
          logic signed [32:0] d0, d1, d2;
          d0 = {org[0][31], org[0]} - {ent.cx[31], ent.cx};
          d1 = {org[1][31], org[1]} - {ent.cy[31], ent.cy};
          d2 = {org[2][31], org[2]} - {ent.cz[31], ent.cz};
          omc_sgn    <= {d2[32], d1[32], d0[32]};
          omc_mag[0] <= MA_W'(d0[32] ? 33'(-d0) : 33'(d0));
          omc_mag[1] <= MA_W'(d1[32] ? 33'(-d1) : 33'(d1));
          omc_mag[2] <= MA_W'(d2[32] ? 33'(-d2) : 33'(d2));
          rad        <= MA_W'(ent.r);
          step       <= '0;
          state      <= ST_DOT;
        end
        ST_DOT: begin
          step <= step + STEP_W'(1);
          if (step == STEP_W'(2)) begin
            state <= ST_BC;
          end
        end
        ST_BC: begin
          // b = floor(dir . omc / 2^F)
          bq    <= acc[MA_W+FRAC_BITS-1:FRAC_BITS];
          bmag  <= acc[MA_W+FRAC_BITS-1] ? MA_W'(-acc[MA_W+FRAC_BITS-1:FRAC_BITS])
                                         : acc[MA_W+FRAC_BITS-1:FRAC_BITS];
          step  <= '0;
          state <= ST_QUAD;
        end
        ST_QUAD: begin
          step <= step + STEP_W'(1);
          if (step == STEP_W'(9)) begin
            state <= ST_CHK;
          end
        end
        ST_CHK: begin
          if (acc[ACC_W-1]) begin
            if (more) begin
              k     <= k_nx;
              state <= ST_RD;
            end else begin
              step  <= '0;
              state <= found ? ST_HIT : ST_FIN;
            end
          end else begin
            sq_x    <= acc[X_W-1:0];
            sq_rem  <= '0;
            sq_root <= '0;
            step    <= '0;
            state   <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          sq_x <= sq_x << 2;
          if (rem_sh >= trial) begin
            sq_rem  <= rem_sh - trial;
            sq_root <= {sq_root[ROOT_W-2:0], 1'b1};
          end else begin
            sq_rem  <= rem_sh;
            sq_root <= {sq_root[ROOT_W-2:0], 1'b0};
          end
          step <= step + STEP_W'(1);
          if (step == STEP_W'(SQ_STEPS - 1)) begin
            state <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          if (upd) begin
            found   <= 1'b1;
            best_t  <= t_sel;
            best_k  <= k[IW-1:0];
            best_in <= t_near[T_W-1];
          end
          if (more) begin
            k     <= k_nx;
            state <= ST_RD;
          end else begin
            step  <= '0;
            state <= (found || upd) ? ST_HIT : ST_FIN;
          end
        end
        ST_HIT: begin
          hp[step[1:0]] <= pt_sat;
          step <= step + STEP_W'(1);
          if (step == STEP_W'(2)) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            o_hit    <= found;
            if (found) begin
              o_idx   <= 4'(best_k);
              o_dist  <= (best_t[T_W-1:31] != '0) ? 31'h7FFFFFFF : best_t[30:0];
              o_ins   <= best_in;
              o_pt[0] <= hp[0];
              o_pt[1] <= hp[1];
              o_pt[2] <= hp[2];
            end else begin
              o_idx   <= '0;
              o_dist  <= '0;
              o_ins   <= 1'b0;
              o_pt[0] <= org[0];
              o_pt[1] <= org[1];
              o_pt[2] <= org[2];
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // checks
  `RSCH_ASSERT(a_miss_zero, (m_tvalid && !m_tuser) |-> (m_tdata[35:0] == 36'd0),
               "miss result carries nonzero slot, distance or inside flag")
  `RSCH_ASSERT(a_sqrt_bound, (state == ST_SQRT) |-> (step < STEP_W'(SQ_STEPS)),
               "square root ran past its step count")
  `RSCH_ASSERT(a_cast_start, cast_acc |=> (state == ST_RD || state == ST_FIN),
               "cast request did not start the sphere walk")
  `RSCH_ASSERT_ALWAYS(a_idx_range,
               m_tvalid |-> (32'(m_tdata[3:0]) < 32'(MAX_SPHERES) || MAX_SPHERES > 16),
               "result slot beyond the table")

endmodule
